FILE: rtl/mlp_pkg.sv
// ----------------------------------------------------------------------------
// mlp_pkg
// Types and constants shared by the multicategory linear predictor modules.
// ----------------------------------------------------------------------------
package mlp_pkg;

    localparam int TAG_W = 6;

    typedef struct packed {
        logic               cmd;
        logic        [7:0]  coef_index;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic        [2:0]  category;
        logic signed [63:0] dot_value;
        logic               last_of_column;
    } t_out_item;

    typedef struct packed {
        logic               valid;
        logic [TAG_W-1:0]   tag;
        logic signed [63:0] prod;
    } t_token;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_chain_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WR,
        S_MAC,
        S_WAIT,
        S_DRAIN
    } t_state;

    typedef enum logic [1:0] {
        REG_NUM_COV     = 2'd0,
        REG_NUM_CAT     = 2'd1,
        REG_COEF_OFFSET = 2'd2,
        REG_SPARE       = 2'd3
    } t_reg_index;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_FEED  = 1'b1;

endpackage

FILE: rtl/multicategory_linear_predictor_unit.sv
// ----------------------------------------------------------------------------
// multicategory_linear_predictor_unit
// Coefficient store plus a chain of per-category accumulators that forms
// saturated Q32.32 dot products of covariate columns with coefficient rows.
// ----------------------------------------------------------------------------
// Input items (i_in, i_in_valid / o_in_stall): cmd 0 writes value into the
// coefficient store at coef_index, cmd 1 feeds one covariate of the column.
// Result items (o_out, o_out_valid / i_out_stall): after the last covariate
// of a column, one item per category in order, last_of_column on the final.
// Registers via APB at 0x0 num_cov, 0x4 num_cat, 0x8 coef_offset.
// Items are taken one at a time. A write stores value once the index has
// been brought below COEF_DEPTH, one subtraction per step if it wraps.
// A feed does, with a subtraction whenever a coefficient index wraps,
// one store read per category through the single read port, one shared
// 32x32 multiply, then every product walks the whole cell row before the
// next item is taken. The column's last feed adds one readout per category.
// A result appears in o_out in the cycle after its readout step. Reset
// clears the sums, column position and valid flags, sets num_cov and num_cat
// to 1 and coef_offset to 0; the store keeps no reset. i_out_stall holds a
// pending result and pauses readout; o_in_stall stays high until it ends.
// ----------------------------------------------------------------------------
module multicategory_linear_predictor_unit
    import mlp_pkg::*;
#(
    parameter int COEF_DEPTH = 256,
    parameter int MAX_COV    = 16,
    parameter int MAX_CAT    = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW  = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
    localparam int AXW = $clog2(COEF_DEPTH + MAX_COV + 256);
    localparam int PW  = (MAX_COV > 1) ? $clog2(MAX_COV) : 1;
    localparam int QW  = $clog2(MAX_COV + 1);
    localparam int CW  = $clog2(MAX_CAT + 1);
    localparam int RW  = (MAX_CAT > 1) ? $clog2(MAX_CAT) : 1;

    logic [4:0]          r_num_cov;
    logic [3:0]          r_num_cat;
    logic [7:0]          r_offset;

    logic [31:0]         r_mem [COEF_DEPTH];

    t_state              r_state;
    t_state              n_state;
    logic [AXW-1:0]      r_addr;
    logic [RW-1:0]       r_c;
    logic [PW-1:0]       r_pos;
    logic signed [31:0]  r_x;
    logic [31:0]         r_wdata;
    logic                r_rd_v;
    logic [RW-1:0]       r_rd_tag;
    logic [31:0]         r_rd_data;
    logic                r_mul_v;
    logic [RW-1:0]       r_mul_tag;
    logic signed [63:0]  r_mul;
    logic                r_out_valid;
    t_out_item           r_out;

    logic [QW-1:0]       w_q;
    logic [CW-1:0]       w_ncat;
    logic                w_addr_ok;
    logic                w_last_cat;
    logic                w_col_end;
    logic                w_out_free;
    logic                w_accept;
    logic                w_cfg_wr;
    logic                w_busy;
    logic signed [63:0]  w_head;
    t_token              w_token;
    t_chain_ctl          w_ctl;

    logic                s_mem_wr;
    logic                s_mem_rd;
    logic                s_sub;
    logic                s_next_cat;
    logic                s_pos_inc;
    logic                s_load_out;
    logic                s_col_done;

    always_comb begin
        if (r_num_cov == '0) begin
            w_q = QW'(1);
        end else if (32'(r_num_cov) > MAX_COV) begin
            w_q = QW'(MAX_COV);
        end else begin
            w_q = QW'(r_num_cov);
        end
        if (r_num_cat == '0) begin
            w_ncat = CW'(1);
        end else if (32'(r_num_cat) > MAX_CAT) begin
            w_ncat = CW'(MAX_CAT);
        end else begin
            w_ncat = CW'(r_num_cat);
        end
    end

    assign w_addr_ok  = r_addr < AXW'(COEF_DEPTH);
    assign w_last_cat = (32'(r_c) + 1) == 32'(w_ncat);
    assign w_col_end  = (32'(r_pos) + 1) >= 32'(w_q);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        n_state    = r_state;
        s_mem_wr   = 1'b0;
        s_mem_rd   = 1'b0;
        s_sub      = 1'b0;
        s_next_cat = 1'b0;
        s_pos_inc  = 1'b0;
        s_load_out = 1'b0;
        s_col_done = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_in.cmd == CMD_WRITE) ? S_WR : S_MAC;
                end
            end
            S_WR: begin
                if (!w_addr_ok) begin
                    s_sub = 1'b1;
                end else begin
                    s_mem_wr = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_MAC: begin
                if (!w_addr_ok) begin
                    s_sub = 1'b1;
                end else begin
                    s_mem_rd = 1'b1;
                    if (w_last_cat) begin
                        n_state = S_WAIT;
                    end else begin
                        s_next_cat = 1'b1;
                    end
                end
            end
            S_WAIT: begin
                if (!r_rd_v && !r_mul_v && !w_busy) begin
                    if (w_col_end) begin
                        n_state = S_DRAIN;
                    end else begin
                        s_pos_inc = 1'b1;
                        n_state   = S_IDLE;
                    end
                end
            end
            S_DRAIN: begin
                if (w_out_free) begin
                    s_load_out = 1'b1;
                    if (w_last_cat) begin
                        s_col_done = 1'b1;
                        n_state    = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c         <= '0;
            r_pos       <= '0;
            r_rd_v      <= 1'b0;
            r_mul_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_v  <= s_mem_rd;
            r_mul_v <= r_rd_v;
            if (w_accept || (r_state == S_WAIT)) begin
                r_c <= '0;
            end else if (s_next_cat || (s_load_out && !s_col_done)) begin
                r_c <= r_c + RW'(1);
            end
            if (s_pos_inc) begin
                r_pos <= r_pos + PW'(1);
            end else if (s_col_done) begin
                r_pos <= '0;
            end
            if (s_load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x     <= i_in.value;
            r_wdata <= i_in.value;
            if (i_in.cmd == CMD_WRITE) begin
                r_addr <= AXW'(i_in.coef_index);
            end else begin
                r_addr <= AXW'(r_offset) + AXW'(r_pos);
            end
        end else if (s_sub) begin
            r_addr <= r_addr - AXW'(COEF_DEPTH);
        end else if (s_next_cat) begin
            r_addr <= r_addr + AXW'(w_q);
        end
        r_rd_tag  <= r_c;
        r_mul_tag <= r_rd_tag;
        r_mul     <= $signed(r_x) * $signed(r_rd_data);
        if (s_load_out) begin
            r_out.category       <= 3'(r_c);
            r_out.dot_value      <= w_head;
            r_out.last_of_column <= w_last_cat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_mem_wr) begin
            r_mem[r_addr[AW-1:0]] <= r_wdata;
        end
        if (s_mem_rd) begin
            r_rd_data <= r_mem[r_addr[AW-1:0]];
        end
    end

    assign w_token.valid = r_mul_v;
    assign w_token.tag   = TAG_W'(r_mul_tag);
    assign w_token.prod  = r_mul;
    assign w_ctl.shift   = s_load_out;
    assign w_ctl.clear   = s_col_done;

    mlp_chain #(
        .MAX_CAT(MAX_CAT)
    ) u_chain (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_token    (w_token),
        .o_head_acc (w_head),
        .o_busy     (w_busy)
    );

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign w_cfg_wr = psel && penable && pwrite;
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_cov <= 5'd1;
            r_num_cat <= 4'd1;
            r_offset  <= 8'd0;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_NUM_COV:     r_num_cov <= pwdata[4:0];
                REG_NUM_CAT:     r_num_cat <= pwdata[3:0];
                REG_COEF_OFFSET: r_offset  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_NUM_COV:     prdata = {27'd0, r_num_cov};
            REG_NUM_CAT:     prdata = {28'd0, r_num_cat};
            REG_COEF_OFFSET: prdata = {24'd0, r_offset};
            default:         prdata = 32'd0;
        endcase
    end

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != S_IDLE))
        else $error("accepted item did not start work");

    a_drain_chain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> (!w_busy && !r_mul_v && !r_rd_v))
        else $error("readout while products still in flight");

    a_read_to_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_v |=> r_mul_v)
        else $error("store read lost before multiply");

endmodule

FILE: rtl/mlp_cell.sv
// ----------------------------------------------------------------------------
// mlp_cell
// One category accumulator: adds the passing product when the tag matches,
// hands the token on, and shifts its sum toward the head on readout.
// ----------------------------------------------------------------------------
module mlp_cell
    import mlp_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_chain_ctl         i_ctl,
    input  t_token             i_token,
    input  logic signed [63:0] i_acc_next,
    output t_token             o_token,
    output logic signed [63:0] o_acc
);

    t_token             r_token;
    logic signed [63:0] r_acc;
    logic signed [63:0] w_sum;
    logic signed [63:0] w_sat;

    assign w_sum = r_acc + i_token.prod;

    always_comb begin
        w_sat = w_sum;
        if ((r_acc[63] == i_token.prod[63]) && (w_sum[63] != r_acc[63])) begin
            w_sat = r_acc[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        r_token.tag  <= i_token.tag;
        r_token.prod <= i_token.prod;
        if (!i_rst_n) begin
            r_token.valid <= 1'b0;
            r_acc         <= '0;
        end else begin
            r_token.valid <= i_token.valid;
            if (i_ctl.clear) begin
                r_acc <= '0;
            end else if (i_ctl.shift) begin
                r_acc <= i_acc_next;
            end else if (i_token.valid && (i_token.tag == TAG_W'(IDX))) begin
                r_acc <= w_sat;
            end
        end
    end

    assign o_token = r_token;
    assign o_acc   = r_acc;

endmodule

FILE: rtl/mlp_chain.sv
// ----------------------------------------------------------------------------
// mlp_chain
// Row of category cells. Products travel from the head outward; sums shift
// back toward the head when a column is read out.
// ----------------------------------------------------------------------------
module mlp_chain
    import mlp_pkg::*;
#(
    parameter int MAX_CAT = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_chain_ctl         i_ctl,
    input  t_token             i_token,
    output logic signed [63:0] o_head_acc,
    output logic               o_busy
);

    t_token             w_tok_out [MAX_CAT];
    logic signed [63:0] w_acc     [MAX_CAT];
    logic [MAX_CAT-1:0] w_tok_v;

    for (genvar k = 0; k < MAX_CAT; k++) begin : g_cell
        t_token             w_tin;
        logic signed [63:0] w_anext;

        if (k == 0) begin : g_head
            assign w_tin = i_token;
        end else begin : g_body
            assign w_tin = w_tok_out[k-1];
        end

        if (k == MAX_CAT - 1) begin : g_tail
            assign w_anext = '0;
        end else begin : g_inner
            assign w_anext = w_acc[k+1];
        end

        mlp_cell #(
            .IDX(k)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (i_ctl),
            .i_token    (w_tin),
            .i_acc_next (w_anext),
            .o_token    (w_tok_out[k]),
            .o_acc      (w_acc[k])
        );

        assign w_tok_v[k] = w_tok_out[k].valid;
    end

    assign o_head_acc = w_acc[0];
    assign o_busy     = |w_tok_v;

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives coefficient writes and covariate columns into the multicategory
// linear predictor under random gaps and stalls, reprograms its registers
// between phases, and checks every result item against a cycle-free model.
// ----------------------------------------------------------------------------

localparam int STORE_DEPTH = 256;
localparam int COV_LIMIT   = 16;
localparam int CAT_LIMIT   = 8;

class column_scoreboard;
    logic signed [31:0] coef [STORE_DEPTH];
    bit                 known [STORE_DEPTH];
    logic signed [63:0] sums [CAT_LIMIT];
    int unsigned        pos;
    logic [4:0]         cov_reg;
    logic [3:0]         cat_reg;
    logic [7:0]         off_reg;
    mlp_pkg::t_out_item expected_q [$];
    int                 errors;

    function new();
        foreach (coef[i]) begin
            coef[i]  = '0;
            known[i] = 1'b0;
        end
        foreach (sums[i]) sums[i] = '0;
        pos     = 0;
        cov_reg = 5'd1;
        cat_reg = 4'd1;
        off_reg = 8'd0;
        errors  = 0;
    endfunction

    function int unsigned cov_len();
        if (cov_reg == 0) return 1;
        return (cov_reg > COV_LIMIT) ? COV_LIMIT : cov_reg;
    endfunction

    function int unsigned cat_count();
        if (cat_reg == 0) return 1;
        return (cat_reg > CAT_LIMIT) ? CAT_LIMIT : cat_reg;
    endfunction

    function int unsigned coef_addr(int unsigned c);
        return (off_reg + c * cov_len() + pos) % STORE_DEPTH;
    endfunction

    function int pending_count();
        return expected_q.size();
    endfunction

    function void write_reg(mlp_pkg::t_reg_index idx, logic [31:0] d);
        case (idx)
            mlp_pkg::REG_NUM_COV:     cov_reg = d[4:0];
            mlp_pkg::REG_NUM_CAT:     cat_reg = d[3:0];
            mlp_pkg::REG_COEF_OFFSET: off_reg = d[7:0];
            default: ;
        endcase
    endfunction

    function logic signed [63:0] sat_add(logic signed [63:0] a, logic signed [63:0] b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return s[63:0];
    endfunction

    function void note_input(mlp_pkg::t_in_item it);
        int unsigned        q;
        int unsigned        n;
        logic signed [63:0] xw;
        logic signed [63:0] bw;
        mlp_pkg::t_out_item r;
        if (it.cmd == mlp_pkg::CMD_WRITE) begin
            coef[it.coef_index]  = it.value;
            known[it.coef_index] = 1'b1;
            return;
        end
        q  = cov_len();
        n  = cat_count();
        xw = $signed(it.value);
        for (int c = 0; c < n; c++) begin
            bw      = coef[coef_addr(c)];
            sums[c] = sat_add(sums[c], xw * bw);
        end
        if (pos + 1 < q) begin
            pos++;
            return;
        end
        for (int c = 0; c < n; c++) begin
            r.category       = c[2:0];
            r.dot_value      = sums[c];
            r.last_of_column = (c == n - 1);
            expected_q.push_back(r);
        end
        foreach (sums[i]) sums[i] = '0;
        pos = 0;
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    endtask

    task check_result(mlp_pkg::t_out_item got);
        mlp_pkg::t_out_item want;
        if (expected_q.size() == 0) begin
            report("unexpected item", got.dot_value, '0);
            return;
        end
        want = expected_q.pop_front();
        if (got.category !== want.category)
            report("category", got.category, want.category);
        if (got.dot_value !== want.dot_value)
            report("dot_value", got.dot_value, want.dot_value);
        if (got.last_of_column !== want.last_of_column)
            report("last_of_column", got.last_of_column, want.last_of_column);
    endtask
endclass

module testbench;
    import mlp_pkg::*;

    localparam int IDLE_CYCLES  = 48;
    localparam int RANDOM_ITEMS = 380;
    localparam int LONG_HOLD    = 300;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in        = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [3:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;

    column_scoreboard sb = new();
    int  sent         = 0;
    bit  steady       = 1'b0;
    int  hold_request = 0;

    multicategory_linear_predictor_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #8_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) sb.check_result(o_out);
    end

    // result side: per-item hold-off, plus one long hold on request
    initial begin
        int n;
        forever begin
            if (hold_request > 0) begin
                n = hold_request;
                hold_request = 0;
            end else begin
                n = steady ? 0 : $urandom_range(0, 12);
            end
            @(negedge i_clk);
            i_out_stall <= (n > 0);
            if (n > 0) begin
                repeat (n) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    task automatic send_item(input t_in_item it);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 12);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in       <= it;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input(it);
        sent++;
    endtask

    task automatic put_coef(input logic [7:0] idx, input logic [31:0] v);
        t_in_item it;
        it.cmd        = CMD_WRITE;
        it.coef_index = idx;
        it.value      = v;
        send_item(it);
    endtask

    function automatic logic [31:0] draw_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '0;
            3, 4:    return $urandom_range(0, 32'h3_FFFF) - 32'h2_0000;
            default: return $urandom();
        endcase
    endfunction

    // loads any coefficient this feed will read that is still unwritten
    task automatic feed(input logic [31:0] v);
        t_in_item    it;
        int unsigned addr;
        for (int c = 0; c < sb.cat_count(); c++) begin
            addr = sb.coef_addr(c);
            if (!sb.known[addr]) put_coef(addr[7:0], draw_value());
        end
        it.cmd        = CMD_FEED;
        it.coef_index = 8'($urandom_range(0, 255));
        it.value      = v;
        send_item(it);
    endtask

    task automatic drain_and_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending_count() != 0) @(posedge i_clk);
        repeat (IDLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_reg(input t_reg_index idx, input logic [31:0] d);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(int'(idx) * 4);
        pwdata  <= d;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.write_reg(idx, d);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        int phase;
        int cov;
        int cat;
        int off;
        int columns;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // single products at the value extremes, reset config
        put_coef(8'd0, 32'h8000_0000);
        feed(32'h8000_0000);
        feed(32'h7FFF_FFFF);
        put_coef(8'd255, 32'h7FFF_FFFF);
        feed(32'h0000_0000);

        // both sums saturate: positive in category 0, negative in category 1
        drain_and_idle();
        set_reg(REG_NUM_COV, 32'd4);
        set_reg(REG_NUM_CAT, 32'd2);
        set_reg(REG_SPARE, 32'hFFFF_FFFF);
        for (int k = 0; k < 4; k++) put_coef(8'(k), 32'h8000_0000);
        for (int k = 4; k < 8; k++) put_coef(8'(k), 32'h7FFF_FFFF);
        repeat (4) feed(32'h8000_0000);

        // zero counts clamp up, oversized counts clamp down, indices wrap
        drain_and_idle();
        set_reg(REG_NUM_COV, 32'd0);
        set_reg(REG_NUM_CAT, 32'd15);
        set_reg(REG_COEF_OFFSET, 32'd250);
        feed(32'h7FFF_FFFF);

        // column length shrinks below the current position
        drain_and_idle();
        set_reg(REG_NUM_COV, 32'd3);
        set_reg(REG_NUM_CAT, 32'd1);
        set_reg(REG_COEF_OFFSET, 32'd0);
        feed(draw_value());
        feed(draw_value());
        drain_and_idle();
        set_reg(REG_NUM_COV, 32'd1);
        feed(draw_value());

        phase = 0;
        while (sent < RANDOM_ITEMS - 20) begin
            drain_and_idle();
            steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) == 0) begin
                case ($urandom_range(0, 3))
                    0:       cov = 0;
                    1:       cov = 31;
                    2:       cov = 17;
                    default: cov = 16;
                endcase
            end else begin
                cov = $urandom_range(1, 8);
            end
            if ($urandom_range(0, 4) == 0) begin
                case ($urandom_range(0, 3))
                    0:       cat = 0;
                    1:       cat = 15;
                    2:       cat = 9;
                    default: cat = 8;
                endcase
            end else begin
                cat = $urandom_range(1, 8);
            end
            case ($urandom_range(0, 4))
                0:       off = 0;
                1:       off = 255;
                default: off = $urandom_range(0, 255);
            endcase
            if (phase == 0) begin
                cov = 2;
                cat = 8;
                steady = 1'b1;
                hold_request = LONG_HOLD;
            end
            set_reg(REG_NUM_COV, 32'(cov));
            set_reg(REG_NUM_CAT, 32'(cat));
            set_reg(REG_COEF_OFFSET, 32'(off));
            if ($urandom_range(0, 5) == 0) set_reg(REG_SPARE, $urandom());

            columns = $urandom_range(2, 6);
            repeat (columns) begin
                for (int j = 0; j < sb.cov_len(); j++) begin
                    if ($urandom_range(0, 9) == 0)
                        put_coef(8'($urandom_range(0, 255)), draw_value());
                    feed(draw_value());
                end
            end
            // sometimes leave a column open across the next reprogramming
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(0, sb.cov_len() - 1)) feed(draw_value());
            phase++;
        end

        drain_and_idle();
        if (sb.errors == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule
